// File: src/sgd_momentum_update_macros.svh
// assertion helpers shared by the velocity memory and the momentum update block
`ifndef SGD_MOMENTUM_UPDATE_MACROS_SVH
`define SGD_MOMENTUM_UPDATE_MACROS_SVH

// same-cycle implication, checked outside reset
`define SGDM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SGDM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/sgdm_pkg.sv
package sgdm_pkg;

    // field widths
    localparam int VAL_W  = 32;
    localparam int IDX_W  = 12;
    localparam int LR_W   = 24;
    localparam int MOM_W  = 16;

    // register indexes, selected by paddr[2]
    localparam logic REG_LR  = 1'b0;
    localparam logic REG_MOM = 1'b1;

    localparam logic [LR_W-1:0]  LR_RESET  = 24'd66;
    localparam logic [MOM_W-1:0] MOM_RESET = 16'd0;

    // configuration seen by the datapath
    typedef struct packed {
        logic [LR_W-1:0]  learning_rate;
        logic [MOM_W-1:0] momentum;
    } t_cfg;

    // velocity memory access strobes
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_mem_ctrl;

endpackage

// File: src/sgdm_cfg.sv
module sgdm_cfg
    import sgdm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    logic [LR_W-1:0]  r_lr;
    logic [MOM_W-1:0] r_mom;
    logic             wr_fire;

    assign pready  = 1'b1;
    assign wr_fire = psel & penable & pwrite & pready;

    // register writes in the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lr  <= LR_RESET;
            r_mom <= MOM_RESET;
        end else if (wr_fire) begin
            if (paddr[2] == REG_LR) begin
                r_lr <= pwdata[LR_W-1:0];
            end else begin
                r_mom <= pwdata[MOM_W-1:0];
            end
        end
    end

    // read mux
    always_comb begin
        if (paddr[2] == REG_MOM) begin
            prdata = {{(32-MOM_W){1'b0}}, r_mom};
        end else begin
            prdata = {{(32-LR_W){1'b0}}, r_lr};
        end
    end

    assign o_cfg.learning_rate = r_lr;
    assign o_cfg.momentum      = r_mom;

endmodule

// File: src/sgdm_vel_mem.sv
`include "sgd_momentum_update_macros.svh"

module sgdm_vel_mem
    import sgdm_pkg::*;
#(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_mem_ctrl        i_ctrl,
    input  logic [AW-1:0]    i_rd_addr,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [VAL_W-1:0] i_wr_data,
    output logic [VAL_W-1:0] o_rd_data,
    output logic             o_busy
);

    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    logic [VAL_W-1:0] mem [DEPTH];
    logic [VAL_W-1:0] r_rd_data;
    logic             r_busy;
    logic [AW-1:0]    r_clr_addr;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [VAL_W-1:0] wr_data;

    // clearing sweep after reset, one entry per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            if (r_clr_addr == LAST_ADDR) begin
                r_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    // write port shared by the sweep and the datapath
    assign wr_en   = r_busy | i_ctrl.wr_en;
    assign wr_addr = r_busy ? r_clr_addr : i_wr_addr;
    assign wr_data = r_busy ? '0 : i_wr_data;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_ctrl.rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_busy;

    `SGDM_ASSERT_IMP(a_no_access_in_clear, i_clk, i_rst_n, r_busy,
        !i_ctrl.rd_en && !i_ctrl.wr_en, "velocity access during clearing sweep")
    `SGDM_ASSERT_NXT(a_clear_runs_once, i_clk, i_rst_n, !r_busy, !r_busy,
        "clearing sweep restarted without reset")
    `SGDM_ASSERT_NXT(a_clear_completes, i_clk, i_rst_n, r_busy && (r_clr_addr != LAST_ADDR),
        r_busy && (r_clr_addr == $past(r_clr_addr) + AW'(1)), "clearing sweep skipped")

endmodule

// File: src/sgd_momentum_update.sv
// sgd with momentum, one weight element per word, velocity kept in an on-chip memory
// states from accept: ADDR, MVEL, NVEL, MSTEP, DONE with momentum; MSTEP, DONE
//   with momentum zero; a new word is taken only after DONE registers the result,
//   owing to the shared 26x32 multiplier and the velocity read-modify-write sequence
// reset: synchronous active low; afterwards a clearing sweep zeroes the velocity
//   memory entry by entry, during which no word is accepted
`include "sgd_momentum_update_macros.svh"

module sgd_momentum_update
    import sgdm_pkg::*;
#(
    parameter int ELEMENT_DEPTH = 4096
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [2:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    // input words
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic signed [VAL_W-1:0] i_weight_value,
    input  logic signed [VAL_W-1:0] i_grad_value,
    input  logic [IDX_W-1:0]        i_element_index,
    // result words
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic signed [VAL_W-1:0] o_new_weight,
    output logic [IDX_W-1:0]        o_out_index
);

    localparam int AW     = (ELEMENT_DEPTH > 1) ? $clog2(ELEMENT_DEPTH) : 1;
    localparam int SH     = 26;
    localparam longint RECIP = ((64'd1 << SH) + longint'(ELEMENT_DEPTH) - 1)
                               / longint'(ELEMENT_DEPTH);
    localparam logic [SH:0] RECIP_W = (SH + 1)'(RECIP);
    localparam logic [20:0] DEPTH_W = 21'(ELEMENT_DEPTH);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ADDR  = 3'd1;
    localparam logic [2:0] S_MVEL  = 3'd2;
    localparam logic [2:0] S_NVEL  = 3'd3;
    localparam logic [2:0] S_MSTEP = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    t_cfg                    cfg;
    t_mem_ctrl               mem_ctrl;
    logic                    mem_busy;
    logic [VAL_W-1:0]        rd_data;

    logic [2:0]              r_state;
    logic [2:0]              n_state;
    logic signed [VAL_W-1:0] r_w;
    logic signed [VAL_W-1:0] r_g;
    logic [IDX_W-1:0]        r_idx;
    logic [IDX_W-1:0]        r_q;
    logic [AW-1:0]           r_slot;
    logic signed [VAL_W-1:0] r_step;
    logic signed [57:0]      r_prod;
    logic                    r_out_valid;
    logic signed [VAL_W-1:0] r_new_weight;
    logic [IDX_W-1:0]        r_out_index;

    logic                    accept;
    logic                    out_load;
    logic                    mom_on;
    logic [IDX_W+SH:0]       q_prod;
    logic [IDX_W-1:0]        q_times_d;
    logic [IDX_W-1:0]        rem;
    logic [AW-1:0]           slot;
    logic signed [25:0]      mul_a;
    logic signed [VAL_W-1:0] mul_b;
    logic signed [57:0]      mul_p;
    logic signed [41:0]      rnd;
    logic signed [VAL_W-1:0] nv;
    logic signed [VAL_W-1:0] nw;

    function automatic logic signed [VAL_W-1:0] sat32(input logic signed [42:0] x);
        logic signed [VAL_W-1:0] res;
        if (x > 43'sd2147483647) begin
            res = 32'sh7fffffff;
        end else if (x < -43'sd2147483648) begin
            res = 32'sh80000000;
        end else begin
            res = x[VAL_W-1:0];
        end
        return res;
    endfunction

    sgdm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    sgdm_vel_mem #(
        .DEPTH (ELEMENT_DEPTH),
        .AW    (AW)
    ) u_vel_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (mem_ctrl),
        .i_rd_addr (slot),
        .i_wr_addr (r_slot),
        .i_wr_data (nv),
        .o_rd_data (rd_data),
        .o_busy    (mem_busy)
    );

    // handshake
    assign mom_on     = (cfg.momentum != '0);
    assign o_in_ready = (r_state == S_IDLE) && !mem_busy;
    assign accept     = i_in_valid && o_in_ready;
    assign out_load   = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    // slot = index modulo depth, by reciprocal multiply then remainder
    assign q_prod    = i_element_index * RECIP_W;
    assign q_times_d = IDX_W'(r_q * DEPTH_W);
    assign rem       = r_idx - q_times_d;
    assign slot      = AW'(rem);

    // shared multiplier: momentum times velocity, then rate times step
    assign mul_a = (r_state == S_MVEL) ? $signed({10'b0, cfg.momentum})
                                       : $signed({2'b0, cfg.learning_rate});
    assign mul_b = (r_state == S_MVEL) ? $signed(rd_data) : r_step;
    assign mul_p = mul_a * mul_b;

    // round to nearest, ties up, back to q16.16
    assign rnd = 42'((r_prod + 58'sd32768) >>> 16);
    assign nv  = sat32(43'(rnd) + 43'(r_g));
    assign nw  = sat32(43'(r_w) - 43'(rnd));

    assign mem_ctrl.rd_en = (r_state == S_ADDR);
    assign mem_ctrl.wr_en = (r_state == S_NVEL);

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = mom_on ? S_ADDR : S_MSTEP;
                end
            end
            S_ADDR:  n_state = S_MVEL;
            S_MVEL:  n_state = S_NVEL;
            S_NVEL:  n_state = S_MSTEP;
            S_MSTEP: n_state = S_DONE;
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_w    <= i_weight_value;
            r_g    <= i_grad_value;
            r_idx  <= i_element_index;
            r_q    <= IDX_W'(q_prod >> SH);
            r_step <= i_grad_value;
        end
        if (r_state == S_ADDR) begin
            r_slot <= slot;
        end
        if (r_state == S_MVEL || r_state == S_MSTEP) begin
            r_prod <= mul_p;
        end
        if (r_state == S_NVEL) begin
            r_step <= nv;
        end
        if (out_load) begin
            r_new_weight <= nw;
            r_out_index  <= r_idx;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_new_weight = r_new_weight;
    assign o_out_index  = r_out_index;

    `SGDM_ASSERT_NXT(a_plain_skips_memory, i_clk, i_rst_n, accept && !mom_on,
        r_state == S_MSTEP, "plain update entered the velocity path")
    `SGDM_ASSERT_IMP(a_write_needs_momentum, i_clk, i_rst_n, mem_ctrl.wr_en,
        mom_on && $past(r_state) == S_MVEL, "velocity written out of sequence")
    `SGDM_ASSERT_NXT(a_result_loaded, i_clk, i_rst_n, out_load,
        r_out_valid && r_state == S_IDLE, "result word not presented")
    `SGDM_ASSERT_IMP(a_no_accept_in_clear, i_clk, i_rst_n, mem_busy,
        !o_in_ready, "word accepted during clearing sweep")

endmodule

// File: tb/sv/sgd_momentum_update_tb.sv
module sgd_momentum_update_tb;
    import sgdm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 400;
    localparam logic signed [VAL_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VAL_W-1:0] WORD_MIN = 32'sh8000_0000;

    typedef struct {
        logic signed [VAL_W-1:0] weight;
        logic signed [VAL_W-1:0] grad;
        logic [IDX_W-1:0]        index;
    } t_update_word;

    typedef struct {
        logic signed [VAL_W-1:0] new_weight;
        logic [IDX_W-1:0]        index;
    } t_result_word;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [2:0]              paddr = '0;
    logic [31:0]             pwdata = '0;
    logic [31:0]             prdata;
    logic                    pready;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_ready;
    logic signed [VAL_W-1:0] i_weight_value = '0;
    logic signed [VAL_W-1:0] i_grad_value = '0;
    logic [IDX_W-1:0]        i_element_index = '0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic signed [VAL_W-1:0] o_new_weight;
    logic [IDX_W-1:0]        o_out_index;

    // mirror of the block's configuration and velocity memory
    logic [LR_W-1:0]         lr_setting = LR_RESET;
    logic [MOM_W-1:0]        mom_setting = MOM_RESET;
    logic signed [VAL_W-1:0] velocity_mirror [4096];

    t_update_word pending_words[$];
    t_result_word predicted_results[$];

    int  error_count = 0;
    int  cycle_count = 0;
    int  hold_left = 0;
    bit  hold_kick = 1'b0;
    bit  no_gaps = 1'b0;

    sgd_momentum_update DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_weight_value  (i_weight_value),
        .i_grad_value    (i_grad_value),
        .i_element_index (i_element_index),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_new_weight    (o_new_weight),
        .o_out_index     (o_out_index)
    );

    // clock, 12 ns period
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // round a Q.32 product to Q16.16, ties toward plus infinity
    function automatic logic signed [63:0] round_to_q16(logic signed [63:0] prod);
        return (prod + 64'sd32768) >>> 16;
    endfunction

    function automatic logic signed [VAL_W-1:0] clamp_word(logic signed [63:0] x);
        if (x > 64'sd2147483647) begin
            return WORD_MAX;
        end else if (x < -64'sd2147483648) begin
            return WORD_MIN;
        end
        return x[VAL_W-1:0];
    endfunction

    // expected new weight for one word, updating the velocity mirror
    function automatic t_result_word compute_update(t_update_word w);
        t_result_word            res;
        logic signed [63:0]      lr_wide;
        logic signed [63:0]      mom_wide;
        logic signed [63:0]      vel_wide;
        logic signed [VAL_W-1:0] step_src;
        logic signed [VAL_W-1:0] new_vel;
        logic signed [63:0]      delta;
        lr_wide  = {40'd0, lr_setting};
        mom_wide = {48'd0, mom_setting};
        step_src = w.grad;
        if (mom_setting != '0) begin
            vel_wide = {{32{velocity_mirror[w.index][31]}}, velocity_mirror[w.index]};
            new_vel = clamp_word(round_to_q16(mom_wide * vel_wide)
                                 + {{32{w.grad[31]}}, w.grad});
            velocity_mirror[w.index] = new_vel;
            step_src = new_vel;
        end
        delta = round_to_q16(lr_wide * {{32{step_src[31]}}, step_src});
        res.new_weight = clamp_word({{32{w.weight[31]}}, w.weight} - delta);
        res.index = w.index;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
        error_count++;
    endtask

    // sender: offers queued words, random gaps between them
    always @(posedge i_clk) begin
        logic offer;
        offer = i_in_valid;
        if (!i_rst_n) begin
            offer = 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                predicted_results.push_back(compute_update(pending_words[0]));
                pending_words.pop_front();
                offer = 1'b0;
            end
            if (!offer && pending_words.size() != 0
                && (no_gaps || $urandom_range(0, 99) >= 11)) begin
                offer = 1'b1;
                i_weight_value  <= pending_words[0].weight;
                i_grad_value    <= pending_words[0].grad;
                i_element_index <= pending_words[0].index;
            end
        end
        i_in_valid <= offer;
    end

    // receiver: checks each result word against the oldest prediction
    always @(posedge i_clk) begin
        t_result_word want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (predicted_results.size() == 0) begin
                report_mismatch("unexpected word, weight", o_new_weight, '0);
            end else begin
                want = predicted_results.pop_front();
                if (o_new_weight !== want.new_weight) begin
                    report_mismatch("new_weight", o_new_weight, want.new_weight);
                end
                if (o_out_index !== want.index) begin
                    report_mismatch("out_index", 32'(o_out_index), 32'(want.index));
                end
            end
        end
        i_out_ready <= i_rst_n && hold_left == 0
                       && (no_gaps || $urandom_range(0, 99) >= 11);
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_kick) begin
            hold_left <= HOLD_CYCLES;
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic queue_word(logic signed [VAL_W-1:0] w, logic signed [VAL_W-1:0] g,
                              logic [IDX_W-1:0] idx);
        t_update_word item;
        item.weight = w;
        item.grad = g;
        item.index = idx;
        pending_words.push_back(item);
    endtask

    // register write; bits above the register width carry random junk
    task automatic write_reg(logic reg_idx, logic [31:0] value);
        logic [31:0] junk_mask;
        junk_mask = (reg_idx == REG_LR) ? 32'hFF00_0000 : 32'hFFFF_0000;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= (value & ~junk_mask) | ($urandom & junk_mask);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_idx == REG_LR) begin
            lr_setting = value[LR_W-1:0];
        end else begin
            mom_setting = value[MOM_W-1:0];
        end
    endtask

    task automatic set_rates(logic [LR_W-1:0] lr, logic [MOM_W-1:0] mom);
        write_reg(REG_LR, 32'(lr));
        write_reg(REG_MOM, 32'(mom));
        @(negedge i_clk);
    endtask

    // wait until every queued word went through and every result came back
    task automatic wait_idle();
        do begin
            @(negedge i_clk);
        end while (pending_words.size() != 0 || predicted_results.size() != 0);
        repeat (8) @(negedge i_clk);
    endtask

    // mix of extremes, full-range and small-magnitude values
    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 4))
                    0: return WORD_MAX;
                    1: return WORD_MIN;
                    2: return '0;
                    3: return -1;
                    default: return 1;
                endcase
            end
            1, 2, 3, 4: return $urandom;
            default: return $signed($urandom) >>> $urandom_range(8, 24);
        endcase
    endfunction

    // stimulus sequence
    initial begin
        logic [LR_W-1:0]  lr_list  [8];
        logic [MOM_W-1:0] mom_list [8];
        logic [IDX_W-1:0] pool [8];
        logic [IDX_W-1:0] idx;

        for (int i = 0; i < 4096; i++) begin
            velocity_mirror[i] = '0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset rates, plain update at the field extremes
        queue_word('0, '0, 12'd0);
        queue_word(WORD_MAX, WORD_MAX, 12'd4095);
        queue_word(WORD_MIN, WORD_MIN, 12'd1);
        queue_word(WORD_MAX, WORD_MIN, 12'd2048);
        queue_word(WORD_MIN, WORD_MAX, 12'd2047);
        queue_word(-1, 1, 12'd5);
        wait_idle();

        // largest step size, saturation of the weight both ways
        set_rates(24'hFF_FFFF, 16'h0000);
        queue_word(WORD_MAX, WORD_MIN, 12'd3);
        queue_word(WORD_MIN, WORD_MAX, 12'd4);
        queue_word('0, 1, 12'd6);
        queue_word('0, -1, 12'd7);
        wait_idle();

        // largest momentum: back-to-back hits on one entry, velocity saturation
        set_rates(24'h01_0000, 16'hFFFF);
        repeat (4) queue_word('0, 32'sh0001_0000, 12'd9);
        repeat (2) queue_word('0, WORD_MAX, 12'd4095);
        repeat (2) queue_word('0, WORD_MIN, 12'd0);
        wait_idle();

        // half momentum and half step: rounding ties
        set_rates(24'h00_8000, 16'h8000);
        queue_word('0, 1, 12'd10);
        queue_word('0, 1, 12'd10);
        queue_word('0, -1, 12'd11);
        queue_word('0, -3, 12'd11);
        wait_idle();

        // random phases, each at its own rates
        lr_list[0] = LR_W'($urandom);  mom_list[0] = MOM_W'($urandom);
        lr_list[1] = 24'd0;            mom_list[1] = 16'd1;
        lr_list[2] = 24'hFF_FFFF;      mom_list[2] = 16'hFFFF;
        lr_list[3] = LR_RESET;         mom_list[3] = 16'd0;
        lr_list[4] = LR_W'($urandom);  mom_list[4] = MOM_W'($urandom);
        lr_list[5] = LR_W'($urandom);  mom_list[5] = 16'd0;
        lr_list[6] = 24'd1;            mom_list[6] = 16'hFFFF;
        lr_list[7] = LR_W'($urandom_range(0, 24'h02_0000));
        mom_list[7] = MOM_W'($urandom);

        for (int ph = 0; ph < 8; ph++) begin
            set_rates(lr_list[ph], mom_list[ph]);
            no_gaps = (ph == 2);
            for (int i = 0; i < 8; i++) begin
                pool[i] = IDX_W'($urandom_range(0, 4095));
            end
            if (ph == 4) begin
                hold_kick = 1'b1;
                @(negedge i_clk);
                hold_kick = 1'b0;
            end
            for (int n = 0; n < 60; n++) begin
                if ($urandom_range(0, 99) < 70) begin
                    idx = pool[3'($urandom_range(0, 7))];
                end else begin
                    idx = IDX_W'($urandom_range(0, 4095));
                end
                queue_word(pick_value(), pick_value(), idx);
            end
            wait_idle();
        end
        no_gaps = 1'b0;

        repeat (20) @(negedge i_clk);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
